FILE: sv/ccc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types, constants and helper functions of the calendar clock counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

  // field widths
  localparam int unsigned MinuteW = 6;
  localparam int unsigned HourW   = 5;
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 7;

  // counter limits
  localparam logic [MinuteW-1:0] MinuteLast = 6'd59;
  localparam logic [HourW-1:0]   HourLast   = 5'd23;
  localparam logic [MonthW-1:0]  MonthLast  = 4'd12;
  localparam logic [YearW-1:0]   YearLast   = 7'd99;
  localparam logic [DayW-1:0]    DayFirst   = 5'd1;
  localparam logic [MonthW-1:0]  MonthFirst = 4'd1;

  // month codes
  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonMar = 4'd3;
  localparam logic [MonthW-1:0] MonApr = 4'd4;
  localparam logic [MonthW-1:0] MonMay = 4'd5;
  localparam logic [MonthW-1:0] MonJun = 4'd6;
  localparam logic [MonthW-1:0] MonJul = 4'd7;
  localparam logic [MonthW-1:0] MonAug = 4'd8;
  localparam logic [MonthW-1:0] MonSep = 4'd9;
  localparam logic [MonthW-1:0] MonOct = 4'd10;
  localparam logic [MonthW-1:0] MonNov = 4'd11;
  localparam logic [MonthW-1:0] MonDec = 4'd12;

  // reset values
  localparam logic [MinuteW-1:0] MinuteRst = 6'd0;
  localparam logic [HourW-1:0]   HourRst   = 5'd0;
  localparam logic [DayW-1:0]    DayRst    = 5'd1;
  localparam logic [MonthW-1:0]  MonthRst  = 4'd1;
  localparam logic [YearW-1:0]   YearRst   = 7'd14;

  // one input request
  typedef struct packed {
    logic               load_time;
    logic               minute_tick;
    logic [HourW-1:0]   new_hour;
    logic [MinuteW-1:0] new_minute;
    logic [DayW-1:0]    new_day;
    logic [MonthW-1:0]  new_month;
    logic [YearW-1:0]   new_year;
  } item_t;

  // clock and calendar state
  typedef struct packed {
    logic [MinuteW-1:0] minute;
    logic [HourW-1:0]   hour;
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
  } time_t;

  // one result request
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [1:0] day_tens;
    logic [3:0] day_ones;
    logic       month_tens;
    logic [3:0] month_ones;
    logic [3:0] year_tens;
    logic [3:0] year_ones;
  } result_t;

  // days in a month, leap February on years divisible by four
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                 input logic [YearW-1:0]  year);
    logic [DayW-1:0] len;
    unique case (month)
      MonFeb:  len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
      MonApr, MonJun, MonSep, MonNov: len = 5'd30;
      MonJan, MonMar, MonMay, MonJul, MonAug, MonOct, MonDec: len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // tens digit of a value below 128, reciprocal multiply by 205/2048
  function automatic logic [3:0] tens_of(input logic [YearW-1:0] value);
    logic [14:0] prod;
    prod = 15'(value) * 15'(8'd205);
    return prod[14:11];
  endfunction

  // ones digit from the value and its tens digit
  function automatic logic [3:0] ones_of(input logic [YearW-1:0] value,
                                         input logic [3:0]       tens);
    logic [YearW-1:0] rem;
    rem = value - 7'(tens) * 7'd10;
    return rem[3:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/ccc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_in_if / ccc_out_if
// Valid/ready channels of the calendar clock counter.
// ----------------------------------------------------------------------------
interface ccc_in_if;
  logic       valid;
  logic       ready;
  logic       load_time;
  logic       minute_tick;
  logic [4:0] new_hour;
  logic [5:0] new_minute;
  logic [4:0] new_day;
  logic [3:0] new_month;
  logic [6:0] new_year;

  modport source (output valid, load_time, minute_tick, new_hour, new_minute,
                  new_day, new_month, new_year, input ready);
  modport sink   (input valid, load_time, minute_tick, new_hour, new_minute,
                  new_day, new_month, new_year, output ready);
endinterface

interface ccc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] hour_tens;
  logic [3:0] hour_ones;
  logic [2:0] minute_tens;
  logic [3:0] minute_ones;
  logic [1:0] day_tens;
  logic [3:0] day_ones;
  logic       month_tens;
  logic [3:0] month_ones;
  logic [3:0] year_tens;
  logic [3:0] year_ones;

  modport source (output valid, hour_tens, hour_ones, minute_tens, minute_ones,
                  day_tens, day_ones, month_tens, month_ones, year_tens,
                  year_ones, input ready);
  modport sink   (input valid, hour_tens, hour_ones, minute_tens, minute_ones,
                  day_tens, day_ones, month_tens, month_ones, year_tens,
                  year_ones, output ready);
endinterface
`default_nettype wire

FILE: sv/ccc_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_in_reg
// Input register: captures one request and holds it until it moves on.
// ----------------------------------------------------------------------------
module ccc_in_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  ccc_in_if.sink              in_ch,
  input  wire logic           fire,
  output ccc_pkg::item_t      item,
  output logic                item_valid
);
  import ccc_pkg::*;

  logic  valid_r;
  item_t item_r;
  logic  take;

  // free when empty or when the held request leaves this cycle
  assign in_ch.ready = !valid_r || fire;
  assign take        = in_ch.valid && in_ch.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (fire) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{load_time:   in_ch.load_time,
                  minute_tick: in_ch.minute_tick,
                  new_hour:    in_ch.new_hour,
                  new_minute:  in_ch.new_minute,
                  new_day:     in_ch.new_day,
                  new_month:   in_ch.new_month,
                  new_year:    in_ch.new_year};
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;
endmodule
`default_nettype wire

FILE: sv/ccc_time_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_time_core
// Time and date registers with load and cascaded minute carry logic.
// ----------------------------------------------------------------------------
module ccc_time_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ccc_pkg::item_t  item,
  input  wire logic            fire,
  output ccc_pkg::time_t       time_nxt
);
  import ccc_pkg::*;

  time_t           time_r;
  time_t           base;
  time_t           stepped;
  logic            min_wrap;
  logic            hour_wrap;
  logic            day_wrap;
  logic            hour_carry;
  logic            day_carry;
  logic            month_carry;
  logic            year_carry;
  logic [DayW-1:0] len;

  // load first, then the tick works on the loaded value
  always_comb begin
    if (item.load_time) begin
      base = '{minute: item.new_minute, hour: item.new_hour, day: item.new_day,
               month: item.new_month, year: item.new_year};
    end else begin
      base = time_r;
    end
  end

  // carry chain minute -> hour -> day -> month -> year
  assign len         = month_len(base.month, base.year);
  assign min_wrap    = base.minute >= MinuteLast;
  assign hour_wrap   = base.hour >= HourLast;
  assign day_wrap    = base.day >= len;
  assign hour_carry  = item.minute_tick && min_wrap;
  assign day_carry   = hour_carry && hour_wrap;
  assign month_carry = day_carry && day_wrap;
  assign year_carry  = month_carry && (base.month >= MonthLast);

  always_comb begin
    stepped = base;
    if (item.minute_tick) begin
      stepped.minute = min_wrap ? '0 : base.minute + 6'd1;
    end
    if (hour_carry) begin
      stepped.hour = hour_wrap ? '0 : base.hour + 5'd1;
    end
    if (day_carry) begin
      stepped.day = day_wrap ? DayFirst : base.day + 5'd1;
    end
    if (month_carry) begin
      // month zero and out-of-range months go back to January
      if (base.month >= MonJan && base.month < MonthLast) begin
        stepped.month = base.month + 4'd1;
      end else begin
        stepped.month = MonthFirst;
      end
    end
    if (year_carry) begin
      stepped.year = (base.year >= YearLast) ? '0 : base.year + 7'd1;
    end
  end

  assign time_nxt = stepped;

  // state update on each request that moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '{minute: MinuteRst, hour: HourRst, day: DayRst,
                  month: MonthRst, year: YearRst};
    end else if (fire) begin
      time_r <= time_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: sv/ccc_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_out_reg
// Decimal digit split and result register of the calendar clock counter.
// ----------------------------------------------------------------------------
module ccc_out_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ccc_pkg::time_t  time_nxt,
  input  wire logic            fire,
  output logic                 slot_free,
  ccc_out_if.source            out_ch
);
  import ccc_pkg::*;

  logic      valid_r;
  result_t   result_r;
  result_t   result_nxt;
  logic [3:0] hour_t;
  logic [3:0] minute_t;
  logic [3:0] day_t;
  logic [3:0] month_t;
  logic [3:0] year_t;

  // tens digits by reciprocal multiply
  assign hour_t   = tens_of(7'(time_nxt.hour));
  assign minute_t = tens_of(7'(time_nxt.minute));
  assign day_t    = tens_of(7'(time_nxt.day));
  assign month_t  = tens_of(7'(time_nxt.month));
  assign year_t   = tens_of(time_nxt.year);

  always_comb begin
    result_nxt.hour_tens   = hour_t[1:0];
    result_nxt.hour_ones   = ones_of(7'(time_nxt.hour), hour_t);
    result_nxt.minute_tens = minute_t[2:0];
    result_nxt.minute_ones = ones_of(7'(time_nxt.minute), minute_t);
    result_nxt.day_tens    = day_t[1:0];
    result_nxt.day_ones    = ones_of(7'(time_nxt.day), day_t);
    result_nxt.month_tens  = month_t[0];
    result_nxt.month_ones  = ones_of(7'(time_nxt.month), month_t);
    result_nxt.year_tens   = year_t;
    result_nxt.year_ones   = ones_of(time_nxt.year, year_t);
  end

  // room for a new result when empty or being drained
  assign slot_free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result_nxt;
    end
  end

  // drive the result channel
  assign out_ch.valid       = valid_r;
  assign out_ch.hour_tens   = result_r.hour_tens;
  assign out_ch.hour_ones   = result_r.hour_ones;
  assign out_ch.minute_tens = result_r.minute_tens;
  assign out_ch.minute_ones = result_r.minute_ones;
  assign out_ch.day_tens    = result_r.day_tens;
  assign out_ch.day_ones    = result_r.day_ones;
  assign out_ch.month_tens  = result_r.month_tens;
  assign out_ch.month_ones  = result_r.month_ones;
  assign out_ch.year_tens   = result_r.year_tens;
  assign out_ch.year_ones   = result_r.year_ones;
endmodule
`default_nettype wire

FILE: sv/calendar_clock_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_clock_counter
// Minute/hour/day/month/year counter with decimal digit outputs.
// ----------------------------------------------------------------------------
// Each request may load the full time and date and may then advance it by one
// minute; every request returns one result with the time and date after it,
// split into tens and ones digits. The block takes one request per clock while
// the result channel takes its results; a request waits in the input register,
// then the load, carry chain and digit split run in one pass into the result
// register while the state registers update.
// After reset the clock reads 00:00 on day 1, month 1, year 14.
// ----------------------------------------------------------------------------
module calendar_clock_counter (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ccc_in_if.sink      in_ch,
  ccc_out_if.source   out_ch
);
  import ccc_pkg::*;

  item_t item;
  logic  item_valid;
  logic  slot_free;
  logic  fire;
  time_t time_nxt;

  // a request moves on when the result register has room
  assign fire = item_valid && slot_free;

  // input register
  ccc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .fire       (fire),
    .item       (item),
    .item_valid (item_valid)
  );

  // time and date state
  ccc_time_core u_time_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (item),
    .fire     (fire),
    .time_nxt (time_nxt)
  );

  // digit split and result register
  ccc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .time_nxt  (time_nxt),
    .fire      (fire),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );
endmodule
`default_nettype wire
